FILE: rtl/core/gfm_pkg.sv
package gfm_pkg;

  // key bits handled by one cell and the resulting cell count
  localparam int unsigned SliceW   = 8;
  localparam int unsigned NumCells = 128 / SliceW;

  // configuration register indexes
  localparam int unsigned CfgIdxW = 2;
  localparam logic [CfgIdxW-1:0] RegKeyLow  = 2'd0;
  localparam logic [CfgIdxW-1:0] RegKeyHigh = 2'd1;
  localparam logic [CfgIdxW-1:0] RegMode    = 2'd2;

  typedef struct packed {
    logic [63:0] operand_high;
    logic [63:0] operand_low;
  } gfm_in_t;

  typedef struct packed {
    logic [63:0] word3;
    logic [63:0] word2;
    logic [63:0] word1;
    logic [63:0] word0;
  } gfm_out_t;

  // what travels from one cell to the next
  typedef struct packed {
    logic [127:0] operand;
    logic [255:0] acc;
  } gfm_lane_t;

  // carry-less product of the operand and one key slice
  function automatic logic [127+SliceW:0] clmul_slice(input logic [127:0] op,
                                                      input logic [SliceW-1:0] b);
    logic [127+SliceW:0] r;
    r = '0;
    for (int i = 0; i < SliceW; i++) begin
      if (b[i]) begin
        r = r ^ ({{SliceW{1'b0}}, op} << i);
      end
    end
    return r;
  endfunction

  // one fold step: x ^ x>>1 ^ x>>2 ^ x>>7
  function automatic logic [127:0] fold128(input logic [127:0] x);
    return x ^ (x >> 1) ^ (x >> 2) ^ (x >> 7);
  endfunction

  // shift the raw product left one bit, then reduce it or hand back the shifted product
  function automatic gfm_out_t finish(input logic [255:0] p, input logic raw);
    logic [255:0] q;
    logic [63:0]  lo;
    logic [63:0]  spill;
    logic [127:0] r;
    gfm_out_t     o;
    q     = {p[254:0], 1'b0};
    lo    = q[63:0];
    spill = (lo << 63) ^ (lo << 62) ^ (lo << 57);
    r     = q[255:128] ^ fold128(q[127:0]) ^ fold128({spill, 64'd0});
    if (raw) begin
      o = q;
    end else begin
      o = {128'd0, r};
    end
    return o;
  endfunction

endpackage

FILE: rtl/core/gfm_cell.sv
module gfm_cell (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          en_i,
  input  logic                          valid_i,
  input  gfm_pkg::gfm_lane_t            lane_i,
  input  logic [gfm_pkg::SliceW-1:0]    key_slice_i,
  output logic                          valid_o,
  output gfm_pkg::gfm_lane_t            lane_o
);

  logic               valid_q;
  gfm_pkg::gfm_lane_t lane_d, lane_q;

  // horner step: shift the partial product up one slice and add this slice's term
  always_comb begin
    lane_d.operand = lane_i.operand;
    lane_d.acc     = {lane_i.acc[255-gfm_pkg::SliceW:0], {gfm_pkg::SliceW{1'b0}}}
                   ^ {{(128-gfm_pkg::SliceW){1'b0}},
                      gfm_pkg::clmul_slice(lane_i.operand, key_slice_i)};
  end

  // occupancy of this cell
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  // data of this cell
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      lane_q <= lane_d;
    end
  end

  assign valid_o = valid_q;
  assign lane_o  = lane_q;

endmodule

FILE: rtl/core/gfm_reduce.sv
module gfm_reduce (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic              valid_i,
  input  logic [255:0]      product_i,
  input  logic              raw_mode_i,
  output logic              valid_o,
  output gfm_pkg::gfm_out_t data_o
);

  logic              valid_q;
  gfm_pkg::gfm_out_t data_d, data_q;

  // shift and fold into the field, or pass the raw product
  always_comb begin
    data_d = gfm_pkg::finish(product_i, raw_mode_i);
  end

  // result beat holds until taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

FILE: rtl/core/gf128_gcm_multiplier_core.sv
// channel | dir | beat                    | handshake
// in      | in  | gfm_in_t operand        | in_valid_i / in_ready_o
// out     | out | gfm_out_t word0..word3  | out_valid_o / out_ready_i
// cfg     | in  | register index and data | cfg_valid_i / cfg_ready_o
//
// one operand beat per cycle unless stalled; 17 register stages: 16 multiply
// cells of 8 key bits each plus the reduce/output stage; the first cell loads
// at the accepting edge and the result leaves the reduce/output register when taken
// reset clears the pipeline valid bits, the key and the mode
// the whole pipeline stalls only while a result waits at the output and
// out_ready_i is low; in_ready_o follows that condition
module gf128_gcm_multiplier_core (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  gfm_pkg::gfm_in_t                in_data_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output gfm_pkg::gfm_out_t               out_data_o,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [gfm_pkg::CfgIdxW-1:0]     cfg_index_i,
  input  logic [63:0]                     cfg_data_i
);

  logic [63:0] key_low_q, key_high_q;
  logic        raw_mode_q;
  logic [127:0] key;
  logic        adv;

  logic               valid [gfm_pkg::NumCells+1];
  gfm_pkg::gfm_lane_t lane  [gfm_pkg::NumCells+1];

  assign cfg_ready_o = 1'b1;
  assign key         = {key_high_q, key_low_q};

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_low_q  <= '0;
      key_high_q <= '0;
      raw_mode_q <= 1'b0;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        gfm_pkg::RegKeyLow:  key_low_q  <= cfg_data_i;
        gfm_pkg::RegKeyHigh: key_high_q <= cfg_data_i;
        gfm_pkg::RegMode:    raw_mode_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // pipeline moves unless a result is held at the output
  assign adv        = !out_valid_o || out_ready_i;
  assign in_ready_o = adv;

  // head of the chain
  assign valid[0]        = in_valid_i;
  assign lane[0].operand = in_data_i;
  assign lane[0].acc     = '0;

  // chain of cells, most significant key slice first
  for (genvar g = 0; g < gfm_pkg::NumCells; g++) begin : g_cell
    gfm_cell u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .en_i        (adv),
      .valid_i     (valid[g]),
      .lane_i      (lane[g]),
      .key_slice_i (key[127-g*gfm_pkg::SliceW -: gfm_pkg::SliceW]),
      .valid_o     (valid[g+1]),
      .lane_o      (lane[g+1])
    );
  end

  // reduction and output register
  gfm_reduce u_reduce (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .en_i       (adv),
    .valid_i    (valid[gfm_pkg::NumCells]),
    .product_i  (lane[gfm_pkg::NumCells].acc),
    .raw_mode_i (raw_mode_q),
    .valid_o    (out_valid_o),
    .data_o     (out_data_o)
  );

endmodule

FILE: tb/sv/gf128_gcm_multiplier_core_test.sv
module gf128_gcm_multiplier_core_test;
  timeunit 1ns;
  timeprecision 1ps;

  // register index the block does not decode
  localparam logic [gfm_pkg::CfgIdxW-1:0] RegUnused = 2'd3;
  // cycles without any beat before the run is declared hung
  localparam int unsigned HangLimit = 4000;
  localparam int unsigned IdlePct   = 34;

  logic                        clk;
  logic                        rst_ni;
  logic                        in_valid_i  = 1'b0;
  logic                        in_ready_o;
  gfm_pkg::gfm_in_t            in_data_i   = '0;
  logic                        out_valid_o;
  logic                        out_ready_i = 1'b0;
  gfm_pkg::gfm_out_t           out_data_o;
  logic                        cfg_valid_i = 1'b0;
  logic                        cfg_ready_o;
  logic [gfm_pkg::CfgIdxW-1:0] cfg_index_i = '0;
  logic [63:0]                 cfg_data_i  = '0;

  // shadow copy of the key and mode as the block should hold them
  logic [127:0]      mult_key = '0;
  logic              raw_mode = 1'b0;
  gfm_pkg::gfm_out_t pending_products[$];
  int unsigned       error_count = 0;
  int unsigned       quiet_cycles = 0;
  bit                no_gaps = 1'b0;

  gf128_gcm_multiplier_core u_top (
    .clk_i       (clk),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  // clock and reset
  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    rst_ni = 1'b0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_ni <= 1'b1;
  end

  // x ^ x>>1 ^ x>>2 ^ x>>7, the fold used by the reflected reduction
  function automatic logic [127:0] spread_bits(input logic [127:0] x);
    logic [127:0] acc;
    acc = x;
    foreach (acc[k]) begin
      acc[k] = x[k] ^ ((k + 1 < 128) ? x[k+1] : 1'b0) ^ ((k + 2 < 128) ? x[k+2] : 1'b0)
               ^ ((k + 7 < 128) ? x[k+7] : 1'b0);
    end
    return acc;
  endfunction

  // expected result of one multiplicand under the current key and mode
  function automatic gfm_pkg::gfm_out_t gcm_product(input logic [127:0] operand,
                                                    input logic [127:0] key,
                                                    input logic         raw);
    logic [255:0] clmul;
    logic [255:0] shifted;
    logic [63:0]  tail;
    logic [63:0]  overflow;
    logic [127:0] reduced;
    clmul = '0;
    for (int i = 0; i < 128; i++) begin
      if (key[i]) begin
        clmul = clmul ^ ({128'd0, operand} << i);
      end
    end
    shifted = clmul << 1;
    if (raw) begin
      return gfm_pkg::gfm_out_t'(shifted);
    end
    // upper half is kept, lower half folded in, then what fell off folded again
    tail     = shifted[63:0];
    overflow = {tail[0], 63'd0} ^ {tail[1:0], 62'd0} ^ {tail[6:0], 57'd0};
    reduced  = shifted[255:128] ^ spread_bits(shifted[127:0])
               ^ spread_bits({overflow, 64'd0});
    return gfm_pkg::gfm_out_t'({128'd0, reduced});
  endfunction

  function automatic logic [63:0] rand_word();
    return {$urandom, $urandom};
  endfunction

  // mostly dense random, with sparse, near-full and half-empty operands mixed in
  function automatic logic [127:0] rand_operand();
    logic [127:0] v;
    v = {rand_word(), rand_word()};
    case ($urandom_range(9))
      0: v = 128'd1 << $urandom_range(127);
      1: v = ~(128'd1 << $urandom_range(127));
      2: v[127:64] = '0;
      3: v[63:0] = '0;
      4: v = v & {rand_word(), rand_word()} & {rand_word(), rand_word()};
      default: ;
    endcase
    return v;
  endfunction

  // send one multiplicand beat and record its expected product
  task automatic send_operand(input logic [127:0] operand);
    @(negedge clk);
    while (!no_gaps && $urandom_range(99) < IdlePct) begin
      in_valid_i <= 1'b0;
      @(negedge clk);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= operand;
    do @(posedge clk); while (!in_ready_o);
    pending_products.push_back(gcm_product(operand, mult_key, raw_mode));
  endtask

  // register write; the shadow follows the block's decode
  task automatic write_reg(input logic [gfm_pkg::CfgIdxW-1:0] idx,
                           input logic [63:0] value);
    @(negedge clk);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= value;
    do @(posedge clk); while (!cfg_ready_o);
    case (idx)
      gfm_pkg::RegKeyLow:  mult_key[63:0]   = value;
      gfm_pkg::RegKeyHigh: mult_key[127:64] = value;
      gfm_pkg::RegMode:    raw_mode         = value[0];
      default: ;
    endcase
    @(negedge clk);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic set_key(input logic [127:0] key);
    write_reg(gfm_pkg::RegKeyLow, key[63:0]);
    write_reg(gfm_pkg::RegKeyHigh, key[127:64]);
  endtask

  // stop sending and let every outstanding product come back
  task automatic wait_drained();
    @(negedge clk);
    in_valid_i <= 1'b0;
    while (pending_products.size() != 0) @(posedge clk);
  endtask

  // receiver stalls
  always @(negedge clk) begin
    out_ready_i <= no_gaps || ($urandom_range(99) >= IdlePct);
  end

  // compare every result beat with the oldest expected product
  always @(posedge clk) begin
    gfm_pkg::gfm_out_t exp_prod;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_products.size() == 0) begin
        $error("result beat with no product expected: %h", out_data_o);
        error_count++;
      end else begin
        exp_prod = pending_products.pop_front();
        if (out_data_o.word0 !== exp_prod.word0) begin
          $error("word0 expected %h actual %h", exp_prod.word0, out_data_o.word0);
          error_count++;
        end
        if (out_data_o.word1 !== exp_prod.word1) begin
          $error("word1 expected %h actual %h", exp_prod.word1, out_data_o.word1);
          error_count++;
        end
        if (out_data_o.word2 !== exp_prod.word2) begin
          $error("word2 expected %h actual %h", exp_prod.word2, out_data_o.word2);
          error_count++;
        end
        if (out_data_o.word3 !== exp_prod.word3) begin
          $error("word3 expected %h actual %h", exp_prod.word3, out_data_o.word3);
          error_count++;
        end
      end
    end
  end

  // hang detection: cycles in which no beat moves on any channel
  always @(posedge clk) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)
        || (cfg_valid_i && cfg_ready_o)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= HangLimit) begin
        $display("status: fail");
        $finish;
      end
    end
  end

  // key and mode come out of reset as zero, so every product is zero
  task automatic test_reset_state();
    send_operand({64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF});
    send_operand({rand_word(), rand_word()});
    wait_drained();
  endtask

  // field extremes and single bits in reduced mode
  task automatic test_reduced_extremes();
    set_key({64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF});
    send_operand('0);
    send_operand('1);
    send_operand(128'd1);
    send_operand(128'd1 << 127);
    send_operand({64'd0, 64'hFFFF_FFFF_FFFF_FFFF});
    send_operand({64'hFFFF_FFFF_FFFF_FFFF, 64'd0});
    wait_drained();
    // multiplicative identity of the reflected convention
    set_key(128'd1 << 127);
    send_operand({rand_word(), rand_word()});
    send_operand(128'd1);
    wait_drained();
    set_key(128'd1);
    send_operand(128'd1);
    send_operand('1);
    send_operand({rand_word(), rand_word()});
    wait_drained();
  endtask

  // raw product, with upper data bits of the mode write ignored
  task automatic test_raw_mode();
    write_reg(gfm_pkg::RegMode, 64'hFFFF_FFFF_FFFF_FFFF);
    set_key('1);
    send_operand('1);
    send_operand(128'd1 << 127);
    send_operand({rand_word(), rand_word()});
    wait_drained();
    // bit 0 clear with the rest set falls back to the reduced product
    write_reg(gfm_pkg::RegMode, 64'hFFFF_FFFF_FFFF_FFFE);
    send_operand('1);
    send_operand({rand_word(), rand_word()});
    wait_drained();
  endtask

  // writes to the undecoded index leave key and mode alone
  task automatic test_unused_index();
    set_key({rand_word(), rand_word()});
    write_reg(RegUnused, 64'hFFFF_FFFF_FFFF_FFFF);
    write_reg(RegUnused, 64'd1);
    send_operand({rand_word(), rand_word()});
    send_operand('1);
    wait_drained();
  endtask

  // random multiplicands across several key and mode settings
  task automatic test_random_stream();
    int unsigned beats;
    for (int phase = 0; phase < 13; phase++) begin
      case (phase)
        0: begin
          set_key('1);
          write_reg(gfm_pkg::RegMode, 64'd0);
        end
        1: write_reg(gfm_pkg::RegMode, rand_word() | 64'd1);
        2: begin
          set_key('0);
          write_reg(gfm_pkg::RegMode, rand_word() & ~64'd1);
        end
        default: begin
          set_key({rand_word(), rand_word()});
          write_reg(gfm_pkg::RegMode, rand_word());
          if ($urandom_range(2) == 0) begin
            write_reg(RegUnused, rand_word());
          end
        end
      endcase
      no_gaps = (phase == 3 || phase == 8);
      beats = (phase == 2) ? 10 : $urandom_range(36, 48);
      for (int n = 0; n < beats; n++) begin
        if (phase == 5 && n == beats / 2) begin
          wait_drained();
        end
        send_operand(rand_operand());
      end
      wait_drained();
    end
    no_gaps = 1'b0;
  endtask

  // test sequence
  initial begin
    @(posedge rst_ni);
    test_reset_state();
    test_reduced_extremes();
    test_raw_mode();
    test_unused_index();
    test_random_stream();
    wait_drained();
    repeat (40) @(posedge clk);
    if (error_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

FILE: files.f
rtl/core/gfm_pkg.sv
rtl/core/gfm_cell.sv
rtl/core/gfm_reduce.sv
rtl/core/gf128_gcm_multiplier_core.sv
tb/sv/gf128_gcm_multiplier_core_test.sv
